>>> design/dtsp_pkg.sv
// Package: constants, types and the height function shared by the stereogram pixel core.
`timescale 1ns / 1ps
`default_nettype none

package dtsp_pkg;

  localparam int PATTERN_WIDTH    = 144;
  localparam int IGNORE_EXPONENTS = 5;
  localparam int EXPONENT_LEVELS  = 6;

  localparam int MAX_SHIFT = PATTERN_WIDTH / 3;
  localparam int STEPS     = MAX_SHIFT / EXPONENT_LEVELS;

  localparam int DEPTH_W = 16;
  localparam int PIXEL_W = 24;
  localparam int MODE_W  = 2;
  localparam int COL_W   = $clog2(PATTERN_WIDTH);
  localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);
  localparam int EXP_W   = $clog2(DEPTH_W);
  localparam int MANT_W  = 9;
  // raw height before clamping: (15 - IGNORE) * STEPS + (511 * STEPS) >> 8
  localparam int RAW_W   = $clog2((DEPTH_W - 1) * STEPS + ((2 ** MANT_W) * STEPS) / 256 + 1);
  localparam int PROD_W  = MANT_W + $clog2(STEPS + 1);

  localparam logic [DEPTH_W-1:0] SKY_DEPTH = 16'h8ccc;

  localparam logic [MODE_W-1:0] MODE_INVERT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GREY   = 2'd3;

  typedef enum logic [1:0] {
    SRC_BACKGROUND,
    SRC_GREY,
    SRC_STORE
  } pix_src_t;

  // Height of a depth value, 0 .. MAX_SHIFT.
  function automatic logic [SHIFT_W-1:0] height_of(input logic [DEPTH_W-1:0] d);
    logic [EXP_W-1:0]   e;
    logic [DEPTH_W-1:0] norm;
    logic [MANT_W-1:0]  m;
    logic [PROD_W-1:0]  prod;
    logic [RAW_W-1:0]   raw;
    e = '0;
    for (int b = 0; b < DEPTH_W; b++) begin
      if (d[b]) e = EXP_W'(b);
    end
    norm = d << (EXP_W'(DEPTH_W - 1) - e);
    m    = norm[DEPTH_W-1 -: MANT_W];
    prod = PROD_W'(m) * PROD_W'(STEPS);
    raw  = RAW_W'(e - EXP_W'(IGNORE_EXPONENTS)) * RAW_W'(STEPS) + RAW_W'(prod >> 8);
    if (d == SKY_DEPTH || e < EXP_W'(IGNORE_EXPONENTS)) begin
      return '0;
    end else if (raw > RAW_W'(MAX_SHIFT)) begin
      return SHIFT_W'(MAX_SHIFT);
    end else begin
      return raw[SHIFT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/depth_to_stereogram_pixel_core.sv
// Top level: random-dot stereogram pixel core with its line store.
`timescale 1ns / 1ps
`default_nettype none

// Random-dot stereogram pixel core.
// Input stream: one screen pixel per transaction. in_tdata carries depth and
// the background pattern pixel, in_tuser flags the first pixel of a row.
// Output stream: one 24-bit pixel per input transaction, in the same order.
// The first PATTERN_WIDTH pixels of a row pass the background; later pixels
// copy the output from (PATTERN_WIDTH - shift) positions back, taken from a
// PATTERN_WIDTH x 24 line store used as a ring. Mode 3 outputs the height
// as grey.
// Pipeline: input register, height stage, state/store-read stage, output
// register. Throughput is one pixel per clock while out_tready is high; the
// store takes one read and one write per cycle. The read address never equals
// the entry written in the same cycle (shift stays below PATTERN_WIDTH - 1), so
// no forwarding is needed. Each stage moves when the stage after it is empty or
// moving, so bubbles close up when out_tready is low and input is still taken
// until full. Reset clears all valids, the row state and display_mode and holds
// in_tready low; the line store is not cleared (every entry is written before
// it is read). display_mode is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while idle, the block itself does not enforce this.
module depth_to_stereogram_pixel_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [dtsp_pkg::MODE_W-1:0]     cfg_wr_data,   // display_mode
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [39:0]                     in_tdata,      // [15:0] depth, [39:16] background
  input  wire logic [0:0]                      in_tuser,      // [0] row_start
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata      // [23:0] pixel
);
  import dtsp_pkg::*;

  // configuration
  logic [MODE_W-1:0] mode_r, mode_nxt;

  // stage 1: registered input
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_row_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic [PIXEL_W-1:0] s1_bg_r;

  // stage 2: height computed
  logic               s2_valid_r, s2_valid_nxt;
  logic               s2_row_r;
  logic [DEPTH_W-1:0] s2_depth_r;
  logic [PIXEL_W-1:0] s2_bg_r;
  logic [SHIFT_W-1:0] s2_height_r;

  // stage 3: pixel source chosen, store read in flight
  logic               s3_valid_r, s3_valid_nxt;
  pix_src_t           s3_src_r;
  logic [PIXEL_W-1:0] s3_bg_r;
  logic [SHIFT_W-1:0] s3_shift_r;
  logic [COL_W-1:0]   s3_pos_r;
  logic [PIXEL_W-1:0] rd_data_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0] out_data_r;

  // row state
  logic [COL_W-1:0]   column_r, column_nxt;
  logic               past_prefix_r, past_prefix_nxt;
  logic [DEPTH_W-1:0] last_depth_r, last_depth_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;

  // line store
  logic [PIXEL_W-1:0] line_store [PATTERN_WIDTH];

  // handshake chain
  logic rdy_out, rdy3, rdy2, rdy1;
  logic s1_load, s2_load, s3_load, out_load;

  // stage 2 -> 3 working values
  logic [COL_W-1:0]   cur_col;
  logic               cur_pp;
  logic [DEPTH_W-1:0] cur_ld;
  logic [SHIFT_W-1:0] cur_shift;
  logic               use_bg;
  logic [COL_W:0]     rd_sum;
  logic [COL_W-1:0]   rd_addr;
  pix_src_t           cur_src;
  logic               col_wrap;

  logic [7:0]         grey;
  logic [PIXEL_W-1:0] px;

  assign rdy_out  = !out_valid_r || out_tready;
  assign rdy3     = !s3_valid_r || rdy_out;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  // no input transaction while reset is held
  assign in_tready = rdy1 && rst_n;

  assign s1_load  = in_tvalid && in_tready;
  assign s2_load  = s1_valid_r && rdy2;
  assign s3_load  = s2_valid_r && rdy3;
  assign out_load = s3_valid_r && rdy_out;

  assign s1_valid_nxt  = s1_load  || (s1_valid_r  && !rdy2);
  assign s2_valid_nxt  = s2_load  || (s2_valid_r  && !rdy3);
  assign s3_valid_nxt  = s3_load  || (s3_valid_r  && !rdy_out);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  // row state update and store read address for the item in stage 2
  always_comb begin
    cur_col   = s2_row_r ? '0 : column_r;
    cur_pp    = s2_row_r ? 1'b0 : past_prefix_r;
    cur_ld    = s2_row_r ? '0 : last_depth_r;
    cur_shift = s2_row_r ? '0 : shift_r;
    use_bg    = !cur_pp && (mode_r != MODE_GREY);

    if (!use_bg && (s2_depth_r != cur_ld)) begin
      cur_ld    = s2_depth_r;
      cur_shift = (mode_r == MODE_INVERT) ? SHIFT_W'(MAX_SHIFT) - s2_height_r : s2_height_r;
    end

    rd_sum = {1'b0, cur_col} + (COL_W+1)'(cur_shift);
    if (rd_sum >= (COL_W+1)'(PATTERN_WIDTH)) begin
      rd_sum = rd_sum - (COL_W+1)'(PATTERN_WIDTH);
    end
    rd_addr = rd_sum[COL_W-1:0];

    if (use_bg) begin
      cur_src = SRC_BACKGROUND;
    end else if (mode_r == MODE_GREY) begin
      cur_src = SRC_GREY;
    end else begin
      cur_src = SRC_STORE;
    end

    col_wrap = (cur_col == COL_W'(PATTERN_WIDTH - 1));

    if (s3_load) begin
      column_nxt      = col_wrap ? '0 : cur_col + 1'b1;
      past_prefix_nxt = cur_pp || col_wrap;
      last_depth_nxt  = cur_ld;
      shift_nxt       = cur_shift;
    end else begin
      column_nxt      = column_r;
      past_prefix_nxt = past_prefix_r;
      last_depth_nxt  = last_depth_r;
      shift_nxt       = shift_r;
    end
  end

  // final pixel select in stage 3
  always_comb begin
    grey = 8'(s3_shift_r);
    case (s3_src_r)
      SRC_BACKGROUND: px = s3_bg_r;
      SRC_GREY:       px = {grey, grey, grey};
      SRC_STORE:      px = rd_data_r;
      default:        px = s3_bg_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= '0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      column_r      <= '0;
      past_prefix_r <= 1'b0;
      last_depth_r  <= '0;
      shift_r       <= '0;
    end else begin
      mode_r        <= mode_nxt;
      s1_valid_r    <= s1_valid_nxt;
      s2_valid_r    <= s2_valid_nxt;
      s3_valid_r    <= s3_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      column_r      <= column_nxt;
      past_prefix_r <= past_prefix_nxt;
      last_depth_r  <= last_depth_nxt;
      shift_r       <= shift_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_row_r   <= in_tuser[0];
      s1_depth_r <= in_tdata[DEPTH_W-1:0];
      s1_bg_r    <= in_tdata[DEPTH_W +: PIXEL_W];
    end
    if (s2_load) begin
      s2_row_r    <= s1_row_r;
      s2_depth_r  <= s1_depth_r;
      s2_bg_r     <= s1_bg_r;
      s2_height_r <= height_of(s1_depth_r);
    end
    if (s3_load) begin
      s3_src_r   <= cur_src;
      s3_bg_r    <= s2_bg_r;
      s3_shift_r <= cur_shift;
      s3_pos_r   <= cur_col;
    end
    if (out_load) begin
      out_data_r <= px;
    end
  end

  // line store: one read when an item enters stage 3, one write when it leaves
  always_ff @(posedge clk) begin
    if (s3_load) begin
      rd_data_r <= line_store[rd_addr];
    end
    if (out_load) begin
      line_store[s3_pos_r] <= px;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> dv/depth_to_stereogram_pixel_core_test.sv
// Self-checking testbench for the stereogram pixel core: directed and random pixel streams.
`timescale 1ns / 1ps

// Test plan
// - A pixel stream goes in over in_*; each input transaction yields exactly one
//   output pixel on out_*, in order. A scoreboard model (stereo_pixel) runs on
//   every accepted input transaction and queues the pixel it expects. The
//   monitor pops the oldest expected pixel for each output transaction and
//   compares it.
// - display_mode is written only when the core is drained: nothing pending,
//   nothing expected.
// - Directed part: grey mode first, since it shows the height of each depth on
//   its own output pixel. Sky depth and its neighbors, depths just below and at
//   the ignore threshold, full-scale depth, repeated depth, depth 0 right after
//   a row start, and a row start in the middle of a row. Then the background
//   extremes in normal mode.
// - Random part: one continuous pixel stream split into six segments, each
//   with its own display mode. Rows mostly run well past the pattern width, so
//   the shifted copy out of the line store is exercised, and some rows wrap
//   the ring more than once. Short rows and rows with no row-start flag act as
//   noise. Depth comes in runs of equal values, so the unchanged-depth path is
//   hit often. Rows carry over segment boundaries, so the mode also changes
//   inside a row.
// - Flow control: segments 0-1 have the sender idle 36% and the receiver 53%,
//   segments 2-3 the reverse, segments 4-5 no idling. In segment 4 the
//   receiver holds off for a long stretch while the sender keeps offering. At
//   every segment boundary the sender waits until all expected pixels are
//   back.
// - The line store is never read before it is written: a read needs a full
//   row prefix, and the first prefix after reset fills every entry.
module depth_to_stereogram_pixel_core_test;
  import dtsp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NORMAL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL_ALT = 2'd1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SEGMENT_PIXELS = 140;

  typedef struct {
    logic                 row_start;
    logic [DEPTH_W-1:0]   depth;
    logic [PIXEL_W-1:0]   background;
  } pixel_item_t;

  // DUT ports, inputs all known from time zero
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [MODE_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata    = '0;    // [15:0] depth, [39:16] background
  logic [0:0]        in_tuser    = '0;    // [0] row_start
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [23:0]       out_tdata;           // [23:0] pixel

  depth_to_stereogram_pixel_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Stimulus and scoreboard queues
  pixel_item_t        pending_pixels[$];
  logic [PIXEL_W-1:0] expected_pixels[$];

  // Flow-control knobs set by the sequence on falling edges; hold_left is the monitor's
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  bit recv_hold_req  = 0;
  int hold_left      = 0;

  // Run statistics
  int mismatch_count = 0;
  int pixels_in      = 0;
  int pixels_out     = 0;
  int rows_started   = 0;
  int prefix_passed  = 0;
  bit [3:0] modes_seen = '0;

  // Scoreboard model state
  logic [MODE_W-1:0]  mode_model = MODE_NORMAL;
  logic [PIXEL_W-1:0] line_ring[PATTERN_WIDTH];
  int                 ring_col   = 0;
  bit                 row_warm   = 0;   // row prefix already passed
  logic [DEPTH_W-1:0] held_depth = '0;
  int                 held_shift = 0;

  // Random stream generator state, carried across segments
  int                 row_left  = 0;
  int                 run_left  = 0;
  logic [DEPTH_W-1:0] run_depth = '0;

  // Height of a depth: sky and shallow values give 0, otherwise the exponent
  // above the ignore threshold times STEPS plus the normalised 9-bit mantissa times STEPS / 256, clamped.
  function automatic int depth_height(logic [DEPTH_W-1:0] d);
    int e;
    int m;
    int h;
    e = 0;
    for (int b = 0; b < DEPTH_W; b++) begin
      if (d[b]) e = b;
    end
    if (d == SKY_DEPTH || e < IGNORE_EXPONENTS) return 0;
    m = d;
    if (e > 8) m = m >> (e - 8);
    else if (e < 8) m = m << (8 - e);
    h = (e - IGNORE_EXPONENTS) * STEPS + ((m * STEPS) >> 8);
    return (h > MAX_SHIFT) ? MAX_SHIFT : h;
  endfunction

  // Advance the scoreboard model by one pixel and return the expected output.
  function automatic logic [PIXEL_W-1:0] stereo_pixel(pixel_item_t it);
    logic [PIXEL_W-1:0] px;
    logic [7:0]         grey;
    int                 h;
    int                 idx;
    if (it.row_start) begin
      ring_col   = 0;
      row_warm   = 0;
      held_depth = '0;
      held_shift = 0;
    end
    if (!row_warm && mode_model != MODE_GREY) begin
      px = it.background;
    end else begin
      // shift follows the mode that was active when depth last changed
      if (it.depth != held_depth) begin
        held_depth = it.depth;
        h = depth_height(it.depth);
        held_shift = (mode_model == MODE_INVERT) ? MAX_SHIFT - h : h;
      end
      if (mode_model == MODE_GREY) begin
        grey = held_shift[7:0];
        px   = {grey, grey, grey};
      end else begin
        idx = ring_col + held_shift;
        if (idx >= PATTERN_WIDTH) idx -= PATTERN_WIDTH;
        px = line_ring[idx];
      end
    end
    line_ring[ring_col] = px;
    ring_col++;
    if (ring_col >= PATTERN_WIDTH) begin
      ring_col = 0;
      if (!row_warm) prefix_passed++;
      row_warm = 1;
    end
    return px;
  endfunction

  // Driver: presents the head of pending_pixels; valid holds until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(stereo_pixel(pending_pixels.pop_front()));
        pixels_in++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_pixels[0].background, pending_pixels[0].depth};
          in_tuser  <= pending_pixels[0].row_start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction, drives out_tready with its own
  // hold-off counter for the long stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        pixels_out++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %06h", $time, out_tdata);
          mismatch_count++;
        end else if (out_tdata !== expected_pixels[0]) begin
          $display("%0t: pixel mismatch, expected %06h, actual %06h",
                   $time, expected_pixels[0], out_tdata);
          mismatch_count++;
          void'(expected_pixels.pop_front());
        end else begin
          void'(expected_pixels.pop_front());
        end
      end
      if (recv_hold_req) begin
        recv_hold_req = 0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles without any transaction on either stream
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_pixel(input logic rs, input logic [DEPTH_W-1:0] d,
                            input logic [PIXEL_W-1:0] bg);
    pixel_item_t it;
    it.row_start = rs;
    it.depth     = d;
    it.background = bg;
    if (rs) rows_started++;
    pending_pixels.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(negedge clk);
  endtask

  // Only called with the core drained, so no input transaction shares the edge.
  task automatic write_mode(input logic [MODE_W-1:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    mode_model  = m;
    modes_seen[m] = 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int b;
    case ($urandom_range(7))
      0: return '0;
      1: return SKY_DEPTH + DEPTH_W'($urandom_range(2)) - DEPTH_W'(1);
      2: return DEPTH_W'($urandom_range(63));
      3: return '1;
      4: begin
        b = $urandom_range(DEPTH_W - 1);
        return (DEPTH_W'(1) << b) | (DEPTH_W'($urandom) & ((DEPTH_W'(1) << b) - 1'b1));
      end
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  // Continuous row stream: mostly rows past the prefix, some short or
  // unflagged rows as noise; depth comes in runs.
  task automatic queue_random_pixels(input int count);
    logic rs;
    for (int i = 0; i < count; i++) begin
      rs = 1'b0;
      if (row_left == 0) begin
        row_left = ($urandom_range(5) == 0) ? $urandom_range(1, 40)
                                            : $urandom_range(PATTERN_WIDTH + 1, 420);
        rs = ($urandom_range(9) != 0);
        run_left = 0;
      end
      if (run_left == 0) begin
        run_left  = $urandom_range(1, 12);
        run_depth = pick_depth();
      end
      push_pixel(rs, run_depth, PIXEL_W'($urandom));
      row_left--;
      run_left--;
    end
  endtask

  logic [MODE_W-1:0] segment_mode[6] = '{MODE_INVERT, MODE_NORMAL, MODE_GREY,
                                         MODE_NORMAL_ALT, MODE_NORMAL, MODE_INVERT};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: heights shown as grey on the same pixel
    write_mode(MODE_GREY);
    push_pixel(1'b1, 16'h0000, 24'h000000);  // depth 0 right after row start
    push_pixel(1'b0, 16'h0000, 24'hffffff);
    push_pixel(1'b0, 16'h001f, 24'h000000);  // just below ignore threshold
    push_pixel(1'b0, 16'h0020, 24'h000000);  // at the threshold
    push_pixel(1'b0, 16'h0021, 24'h000000);
    push_pixel(1'b0, SKY_DEPTH, 24'h000000); // sky
    push_pixel(1'b0, 16'h8ccb, 24'h000000);
    push_pixel(1'b0, 16'h8ccd, 24'h000000);
    push_pixel(1'b0, 16'h0100, 24'h000000);
    push_pixel(1'b0, 16'h01ff, 24'h000000);
    push_pixel(1'b0, 16'h7fff, 24'h000000);
    push_pixel(1'b0, 16'hffff, 24'h000000);  // full scale, clamped
    push_pixel(1'b0, 16'hffff, 24'h000000);  // unchanged depth
    push_pixel(1'b1, 16'h4000, 24'h000000);  // row start mid-row
    push_pixel(1'b0, 16'h8000, 24'h000000);
    wait_drained();

    // Directed: background passthrough in the prefix
    write_mode(MODE_NORMAL);
    push_pixel(1'b1, 16'hffff, 24'hffffff);
    push_pixel(1'b0, 16'h0000, 24'h000000);
    push_pixel(1'b0, 16'h1234, 24'h5a5a5a);
    push_pixel(1'b0, 16'h0000, 24'ha5a5a5);
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 36; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_mode(segment_mode[seg]);
      queue_random_pixels(SEGMENT_PIXELS);
      // long receiver stall with the sender still offering: the pipe fills
      if (seg == 4) recv_hold_req = 1;
      // sender pauses here until every expected pixel is back
      wait_drained();
    end

    repeat (12) @(posedge clk);
    $display("Covered %0d pixels in, %0d out, %0d flagged rows, %0d row prefixes passed,",
             pixels_in, pixels_out, rows_started, prefix_passed);
    $display("display modes seen (bit per mode): %04b, with stalls on both streams",
             modes_seen);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
